/* design/wdevd_pkg.sv */
// ============================================================================
// wdevd_pkg: shared types and constants of the dual-energy voice detector
// Register codes, configuration struct, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package wdevd_pkg;

    localparam int MAX_CONTEXT_DEF = 15;
    localparam int ENERGY_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register field widths
    localparam int CTX_W   = 4;
    localparam int THR_W   = 16;
    localparam int SCALE_W = 16;
    localparam int PROP_W  = 17;

    // fixed-point fraction bits
    localparam int SCALE_FRAC = 12;
    localparam int PROP_FRAC  = 16;

    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_RATIO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_PROP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_PROP    = 3'd4;

    localparam logic [SCALE_W-1:0] ENERGY_SCALE_RST = 16'd4096;
    localparam logic [PROP_W-1:0]  PROP_RST         = 17'd32768;

    typedef struct packed {
        logic [CTX_W-1:0]          ctx_frames;
        logic signed [THR_W-1:0]   log_ratio;
        logic [SCALE_W-1:0]        energy_scale;
        logic [PROP_W-1:0]         strong_prop;
        logic [PROP_W-1:0]         weak_prop;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MIN,
        ST_MIN_DRAIN,
        ST_PROD,
        ST_CNT,
        ST_CNT_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic admit;      // take the input beat into the window
        logic start_dec;  // set up bounds for the next decided frame
        logic rd_min;     // read one window entry, minimum pass
        logic rd_cnt;     // read one window entry, counting pass
        logic load_prod;  // register threshold products, rewind pointer
        logic decide;     // load the output register
        logic finish;     // close the step
    } t_dp_cmd;

    typedef struct packed {
        logic more;       // another frame is due for a decision
        logic ptr_last;   // pointer sits on the window's last frame
        logic out_free;   // output register can take a beat
    } t_dp_status;

endpackage

`default_nettype wire

/* design/windowed_dual_energy_voice_detector_core.sv */
// ============================================================================
// windowed_dual_energy_voice_detector_core: frame voice activity decision
// Top level: configuration registers, sequencer and windowed datapath.
// ============================================================================
//
// Takes one frame beat (strong and weak log energy, signed Q8.8) when idle
// and emits one voiced flag per frame, C frames late; a beat with tlast set
// flushes all pending decisions and the last one leaves with tlast. Each
// decision reads its centred window of n frames (n up to 2C+1) twice out of
// a ring memory with one write and one read port, one entry per cycle:
// once for the channel minima and once for the strong/weak counts. No new
// frame is accepted until every decision due for the last one is made. A
// finished result waits in the output register while the next frame is
// taken; the block stalls only when a new decision finds that register
// still full.
`default_nettype none

module windowed_dual_energy_voice_detector_core #(
    parameter int MAX_CONTEXT = wdevd_pkg::MAX_CONTEXT_DEF,
    parameter int ENERGY_BITS = wdevd_pkg::ENERGY_BITS_DEF,
    localparam int DATA_W     = ((2 * ENERGY_BITS + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wdevd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wdevd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [DATA_W-1:0]                i_s_tdata,  // strong_energy, weak_energy
    input  wire logic                             i_s_tlast,  // end_of_utterance
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [wdevd_pkg::OUT_DATA_W-1:0]      o_m_tdata,  // voiced
    output logic                                  o_m_tlast   // final_decision
);

    wdevd_pkg::t_cfg       r_cfg;
    wdevd_pkg::t_dp_cmd    cmd;
    wdevd_pkg::t_dp_status sts;
    logic                  voiced;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctx_frames   <= '0;
            r_cfg.log_ratio    <= '0;
            r_cfg.energy_scale <= wdevd_pkg::ENERGY_SCALE_RST;
            r_cfg.strong_prop  <= wdevd_pkg::PROP_RST;
            r_cfg.weak_prop    <= wdevd_pkg::PROP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wdevd_pkg::CFG_CONTEXT: begin
                    r_cfg.ctx_frames <= i_cfg_data[wdevd_pkg::CTX_W-1:0];
                end
                wdevd_pkg::CFG_LOG_RATIO: begin
                    r_cfg.log_ratio <= $signed(i_cfg_data[wdevd_pkg::THR_W-1:0]);
                end
                wdevd_pkg::CFG_ENERGY_SCALE: begin
                    r_cfg.energy_scale <= i_cfg_data[wdevd_pkg::SCALE_W-1:0];
                end
                wdevd_pkg::CFG_STRONG_PROP: begin
                    r_cfg.strong_prop <= i_cfg_data[wdevd_pkg::PROP_W-1:0];
                end
                wdevd_pkg::CFG_WEAK_PROP: begin
                    r_cfg.weak_prop <= i_cfg_data[wdevd_pkg::PROP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wdevd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready)
    );

    wdevd_dp #(
        .MAX_CONTEXT (MAX_CONTEXT),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_frame     (i_s_tdata[2*ENERGY_BITS-1:0]),
        .i_eou       (i_s_tlast),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_voiced    (voiced),
        .o_final     (o_m_tlast)
    );

    assign o_m_tdata = {{(wdevd_pkg::OUT_DATA_W-1){1'b0}}, voiced};

endmodule

`default_nettype wire

/* design/wdevd_ctrl.sv */
// ============================================================================
// wdevd_ctrl: sequencer of the voice detector
// Walks each frame through admission, the minimum pass, the counting pass
// and the output load, once per due decision.
// ============================================================================
`default_nettype none

module wdevd_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire wdevd_pkg::t_dp_status i_sts,
    output wdevd_pkg::t_dp_cmd         o_cmd,
    output logic                       o_s_tready
);

    wdevd_pkg::t_state r_state;
    wdevd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdevd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wdevd_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = wdevd_pkg::ST_CHECK;
            end
            wdevd_pkg::ST_CHECK: begin
                n_state = i_sts.more ? wdevd_pkg::ST_MIN : wdevd_pkg::ST_IDLE;
            end
            wdevd_pkg::ST_MIN: begin
                if (i_sts.ptr_last) n_state = wdevd_pkg::ST_MIN_DRAIN;
            end
            wdevd_pkg::ST_MIN_DRAIN: begin
                n_state = wdevd_pkg::ST_PROD;
            end
            wdevd_pkg::ST_PROD: begin
                n_state = wdevd_pkg::ST_CNT;
            end
            wdevd_pkg::ST_CNT: begin
                if (i_sts.ptr_last) n_state = wdevd_pkg::ST_CNT_DRAIN;
            end
            wdevd_pkg::ST_CNT_DRAIN: begin
                n_state = wdevd_pkg::ST_DECIDE;
            end
            wdevd_pkg::ST_DECIDE: begin
                if (i_sts.out_free) n_state = wdevd_pkg::ST_CHECK;
            end
            default: begin
                n_state = wdevd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            wdevd_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.admit = i_s_tvalid;
            end
            wdevd_pkg::ST_CHECK: begin
                o_cmd.start_dec = i_sts.more;
                o_cmd.finish    = !i_sts.more;
            end
            wdevd_pkg::ST_MIN: begin
                o_cmd.rd_min = 1'b1;
            end
            wdevd_pkg::ST_PROD: begin
                o_cmd.load_prod = 1'b1;
            end
            wdevd_pkg::ST_CNT: begin
                o_cmd.rd_cnt = 1'b1;
            end
            wdevd_pkg::ST_DECIDE: begin
                o_cmd.decide = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/wdevd_dp.sv */
// ============================================================================
// wdevd_dp: window memory and decision datapath of the voice detector
// Holds the frame ring, the buffer counters, the minimum and counting
// passes over one centred window and the output register.
// ============================================================================
`default_nettype none

module wdevd_dp #(
    parameter int MAX_CONTEXT = wdevd_pkg::MAX_CONTEXT_DEF,
    parameter int ENERGY_BITS = wdevd_pkg::ENERGY_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wdevd_pkg::t_cfg            i_cfg,
    input  wire wdevd_pkg::t_dp_cmd         i_cmd,
    output wdevd_pkg::t_dp_status           o_sts,
    input  wire logic [2*ENERGY_BITS-1:0]   i_frame,   // strong, weak
    input  wire logic                       i_eou,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_voiced,
    output logic                            o_final
);

    localparam int EB   = ENERGY_BITS;
    localparam int W    = 2 * MAX_CONTEXT + 2;
    localparam int AW   = $clog2(W);
    localparam int FBW  = $clog2(W + 1);
    localparam int SW   = FBW + 1;
    localparam int CAP  = MAX_CONTEXT + 1;
    localparam int CNTW = $clog2(CAP + 1);
    localparam int DENW = $clog2(W);
    localparam int MDW  = EB + 1;
    localparam int DIFW = (EB + 2 > wdevd_pkg::THR_W) ? EB + 2 : wdevd_pkg::THR_W;
    localparam int PW   = EB + wdevd_pkg::SCALE_W + 1;
    localparam int QW   = DENW + wdevd_pkg::PROP_W;

    logic [2*EB-1:0]      r_mem [W];
    logic [2*EB-1:0]      r_rd_data;
    logic                 r_vld_min;
    logic                 r_vld_cnt;

    logic [AW-1:0]        r_ws;
    logic [FBW-1:0]       r_fb;
    logic [FBW-1:0]       r_nd;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_eou;

    logic [FBW-1:0]       r_lo;
    logic [FBW-1:0]       r_hi;
    logic [FBW-1:0]       r_ptr;

    logic signed [EB-1:0] r_min_s;
    logic signed [EB-1:0] r_min_w;
    logic signed [PW-1:0] r_prod_s;
    logic signed [PW-1:0] r_prod_w;
    logic signed [MDW-1:0] r_mdiff;
    logic [DENW-1:0]      r_nstrong;
    logic [DENW-1:0]      r_nweak;

    logic                 r_out_vld;
    logic                 r_voiced;
    logic                 r_final;

    // admission
    logic [FBW-1:0]       c;
    logic [FBW-1:0]       drop;
    logic [FBW-1:0]       fb_a;
    logic [FBW-1:0]       nd_a;
    logic [FBW-1:0]       fb_b;
    logic [FBW-1:0]       nd_b;
    logic [FBW-1:0]       fb_new;
    logic [FBW-1:0]       nd_new;
    logic [AW-1:0]        ws_new;

    // window bounds and addressing
    logic [FBW-1:0]       fb_m1;
    logic [FBW:0]         hi_sum;
    logic [FBW-1:0]       lo_n;
    logic [FBW-1:0]       hi_n;
    logic [FBW-1:0]       fb_mod;
    logic [SW-1:0]        base;
    logic [SW-1:0]        slot;
    logic [AW-1:0]        rd_addr;

    // per-entry tests
    logic signed [EB-1:0]   rd_s;
    logic signed [EB-1:0]   rd_w;
    logic signed [MDW-1:0]  sw_diff;
    logic signed [DIFW-1:0] ratio;
    logic                   is_strong;
    logic                   is_weak;

    // decision
    logic [DENW-1:0]      den;
    logic [QW-1:0]        strong_lhs;
    logic [QW-1:0]        weak_lhs;
    logic                 voiced_n;
    logic                 final_n;

    always_comb begin
        if (32'(i_cfg.ctx_frames) > MAX_CONTEXT) begin
            c = FBW'(MAX_CONTEXT);
        end else begin
            c = FBW'(i_cfg.ctx_frames);
        end

        // drop frames that fell out of the window after a context change
        drop = '0;
        if (r_nd > c) begin
            drop = r_nd - c;
            if (drop > r_fb) drop = r_fb;
        end
        fb_a = r_fb - drop;
        nd_a = r_nd - drop;

        fb_b = fb_a;
        nd_b = nd_a;
        if (fb_a >= FBW'(W)) begin
            fb_b = FBW'(W - 1);
            if (nd_a != '0) nd_b = nd_a - FBW'(1);
        end
        nd_new = (nd_b > fb_b) ? fb_b : nd_b;
        fb_new = fb_b + FBW'(1);
        ws_new = (r_ws == AW'(W - 1)) ? '0 : r_ws + AW'(1);
    end

    always_comb begin
        fb_m1  = r_fb - FBW'(1);
        hi_sum = {1'b0, r_nd} + {1'b0, c};
        lo_n   = (r_nd > c) ? r_nd - c : '0;
        hi_n   = (hi_sum < {1'b0, fb_m1}) ? FBW'(hi_sum) : fb_m1;

        // oldest held frame sits frames_buffered slots behind the write slot
        fb_mod = (r_fb == FBW'(W)) ? '0 : r_fb;
        base   = SW'(r_ws) + SW'(W) - SW'(fb_mod);
        if (base >= SW'(W)) base = base - SW'(W);
        slot   = base + SW'(r_ptr);
        if (slot >= SW'(W)) slot = slot - SW'(W);
        rd_addr = AW'(slot);

        o_sts.more = (r_nd < r_fb) && (r_cnt < CNTW'(CAP)) &&
                     (r_eou || ((fb_m1 - r_nd) >= c));
        o_sts.ptr_last = (r_ptr == r_hi);
        o_sts.out_free = !r_out_vld || i_out_ready;
    end

    always_comb begin
        rd_s      = $signed(r_rd_data[EB-1:0]);
        rd_w      = $signed(r_rd_data[2*EB-1:EB]);
        // (s - ms) - (w - mw) regrouped as (s - w) - (ms - mw)
        sw_diff   = MDW'(rd_s) - MDW'(rd_w);
        ratio     = DIFW'(sw_diff) - DIFW'(r_mdiff);
        is_strong = (ratio > DIFW'($signed(i_cfg.log_ratio))) &&
                    ((PW'(rd_s) <<< wdevd_pkg::SCALE_FRAC) > r_prod_s);
        is_weak   = !is_strong &&
                    ((PW'(rd_w) <<< wdevd_pkg::SCALE_FRAC) > r_prod_w);
    end

    always_comb begin
        den        = DENW'(r_hi - r_lo + FBW'(1));
        strong_lhs = QW'({r_nstrong, {wdevd_pkg::PROP_FRAC{1'b0}}});
        weak_lhs   = QW'({r_nweak, {wdevd_pkg::PROP_FRAC{1'b0}}});
        voiced_n   = (strong_lhs >= QW'(den) * QW'(i_cfg.strong_prop)) &&
                     (weak_lhs < QW'(den) * QW'(i_cfg.weak_prop));
        final_n    = r_eou && (r_nd == fb_m1);
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.admit) begin
            r_mem[r_ws] <= i_frame;
        end
        if (i_cmd.rd_min || i_cmd.rd_cnt) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_fb      <= '0;
            r_nd      <= '0;
            r_cnt     <= '0;
            r_eou     <= 1'b0;
            r_vld_min <= 1'b0;
            r_vld_cnt <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld_min <= i_cmd.rd_min;
            r_vld_cnt <= i_cmd.rd_cnt;
            if (i_cmd.admit) begin
                r_ws  <= ws_new;
                r_fb  <= fb_new;
                r_nd  <= nd_new;
                r_cnt <= '0;
                r_eou <= i_eou;
            end
            if (i_cmd.decide) begin
                r_nd  <= r_nd + FBW'(1);
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (i_cmd.finish) begin
                r_cnt <= '0;
                if (r_eou) begin
                    r_fb <= '0;
                    r_nd <= '0;
                end
            end
            if (i_cmd.decide) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_dec) begin
            r_lo    <= lo_n;
            r_hi    <= hi_n;
            r_ptr   <= lo_n;
            r_min_s <= $signed({1'b0, {(EB-1){1'b1}}});
            r_min_w <= $signed({1'b0, {(EB-1){1'b1}}});
        end
        if (i_cmd.rd_min || i_cmd.rd_cnt) begin
            r_ptr <= r_ptr + FBW'(1);
        end
        if (r_vld_min) begin
            if (rd_s < r_min_s) r_min_s <= rd_s;
            if (rd_w < r_min_w) r_min_w <= rd_w;
        end
        if (i_cmd.load_prod) begin
            r_prod_s  <= PW'($signed({1'b0, i_cfg.energy_scale})) * PW'(r_min_s);
            r_prod_w  <= PW'($signed({1'b0, i_cfg.energy_scale})) * PW'(r_min_w);
            r_mdiff   <= MDW'(r_min_s) - MDW'(r_min_w);
            r_ptr     <= r_lo;
            r_nstrong <= '0;
            r_nweak   <= '0;
        end
        if (r_vld_cnt) begin
            if (is_strong) begin
                r_nstrong <= r_nstrong + DENW'(1);
            end else if (is_weak) begin
                r_nweak <= r_nweak + DENW'(1);
            end
        end
        if (i_cmd.decide) begin
            r_voiced <= voiced_n;
            r_final  <= final_n;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_voiced    = r_voiced;
    assign o_final     = r_final;

    a_nd_within_fb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= r_fb)
        else $error("decided offset ran past the buffered frames");

    a_fb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fb <= FBW'(W))
        else $error("frame count exceeds the window memory");

    a_window_holds_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_dec |=> (r_lo <= r_nd) && (r_nd <= r_hi) && (r_hi < r_fb))
        else $error("window bounds miss the decided frame");

    a_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_vld_min && r_vld_cnt))
        else $error("minimum and counting reads overlap");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(CAP))
        else $error("too many decisions in one step");

endmodule

`default_nettype wire
